FILE: design/ssed_pkg.sv
package ssed_pkg;

	localparam int ROW_BITS      = 10;
	localparam int COL_OUT_BITS  = 10;
	localparam int COUNT_BITS    = 20;
	localparam int CFG_BITS      = 11;
	localparam int CFG_IDX_BITS  = 1;
	localparam int SCALES        = 3;
	localparam int WIN_SIZE      = 27;
	localparam int WIN_CENTRE    = 13;
	localparam int SCALE_TAPS    = 9;
	localparam int ROW_TAPS      = 3;
	localparam int OUT_DEPTH     = 4;
	localparam int OUT_PTR_BITS  = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;
	localparam logic [CFG_BITS-1:0] MIN_SIZE     = 11'd3;
	localparam logic [CFG_BITS-1:0] MAX_HEIGHT   = 11'd1024;

	// Scale order in all per-scale arrays
	localparam int SCALE_LOW  = 0;
	localparam int SCALE_MID  = 1;
	localparam int SCALE_HIGH = 2;

	typedef struct packed {
		logic                    emit;
		logic                    clr;
		logic [ROW_BITS-1:0]     centre_row;
		logic [COL_OUT_BITS-1:0] centre_col;
		logic                    frame_done;
	} ctrl_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]     centre_row;
		logic [COL_OUT_BITS-1:0] centre_col;
		logic                    is_extremum;
		logic [COUNT_BITS-1:0]   extrema_count;
		logic                    frame_done;
	} res_t;

endpackage

FILE: design/ssed_ifs.sv
interface ssed_pix_if #(parameter int PIXEL_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pix_mid;
	logic signed [PIXEL_BITS-1:0] pix_low;
	logic signed [PIXEL_BITS-1:0] pix_high;
	logic                         start_of_frame;

	modport source (output valid, pix_mid, pix_low, pix_high, start_of_frame, input ready);
	modport sink (input valid, pix_mid, pix_low, pix_high, start_of_frame, output ready);
endinterface

interface ssed_res_if import ssed_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [ROW_BITS-1:0]     centre_row;
	logic [COL_OUT_BITS-1:0] centre_col;
	logic                    is_extremum;
	logic [COUNT_BITS-1:0]   extrema_count;
	logic                    frame_done;

	modport source (output valid, centre_row, centre_col, is_extremum, extrema_count,
		frame_done, input ready);
	modport sink (input valid, centre_row, centre_col, is_extremum, extrema_count,
		frame_done, output ready);
endinterface

FILE: design/scale_space_extrema_detector_unit.sv
// Scale-space 3x3x3 extrema detector. Takes one pixel triple (lower, middle,
// upper scale) per cycle in raster order while input ready is high and gives,
// for every interior centre, its coordinates, the extremum flag and the running
// extremum count of the frame. Each result passes through stage 1, the window
// stage and the output queue. Throughput is set by the column read-modify-write
// of the line memory, which completes a pixel every cycle. Input ready falls only
// when the results held in the four-entry output queue plus the pixels in the two
// pipeline stages reach four. The user must write image size through the config
// port only while the stream is idle; the block itself does not enforce this.
module scale_space_extrema_detector_unit import ssed_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	ssed_pix_if.sink                pix_in,
	ssed_res_if.source              res_out
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS + 1;
	localparam int DW   = SCALES * 2 * PIXEL_BITS;

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	logic [ROW_BITS-1:0] row_q;
	logic [CW-1:0]       col_q;

	logic                acc;
	logic [ROW_BITS-1:0] row_cur;
	logic [CW-1:0]       col_cur;
	logic [CW-1:0]       col_m1;
	logic [CMPW-1:0]     w_ext;
	logic [CMPW-1:0]     w_eff;
	logic [CFG_BITS-1:0] h_eff;
	logic [CMPW-1:0]     col_inc;
	logic [CFG_BITS-1:0] row_inc;
	logic                wrap_col;
	logic                wrap_row;
	ctrl_t               ctrl_cur;

	logic                         v_s1;
	ctrl_t                        ctrl_s1;
	logic [CW-1:0]                col_s1;
	logic signed [PIXEL_BITS-1:0] pix_s1 [SCALES];

	logic [DW-1:0]                rd_data;
	logic [DW-1:0]                wr_data;
	logic signed [PIXEL_BITS-1:0] top_s1 [SCALES];
	logic signed [PIXEL_BITS-1:0] mid_s1 [SCALES];

	logic                  v_s2;
	logic                  res_push;
	res_t                  res_data;
	logic [OUT_PTR_BITS:0] level;
	logic [OUT_PTR_BITS:0] inflight;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raster position and wrap
	assign acc     = pix_in.valid && pix_in.ready;
	assign row_cur = pix_in.start_of_frame ? '0 : row_q;
	assign col_cur = pix_in.start_of_frame ? '0 : col_q;
	assign col_m1  = col_cur - CW'(1);

	always_comb begin
		w_ext = CMPW'(width_q);
		if (w_ext < CMPW'(MIN_SIZE)) begin
			w_eff = CMPW'(MIN_SIZE);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_q < MIN_SIZE) begin
			h_eff = MIN_SIZE;
		end else if (height_q > MAX_HEIGHT) begin
			h_eff = MAX_HEIGHT;
		end else begin
			h_eff = height_q;
		end
	end

	assign col_inc  = CMPW'(col_cur) + CMPW'(1);
	assign row_inc  = CFG_BITS'(row_cur) + CFG_BITS'(1);
	assign wrap_col = (col_inc >= w_eff);
	assign wrap_row = (row_inc >= h_eff);

	always_comb begin
		ctrl_cur.emit       = (row_cur >= ROW_BITS'(2)) && (col_cur >= CW'(2));
		ctrl_cur.clr        = (row_cur == '0) && (col_cur == '0);
		ctrl_cur.centre_row = row_cur - ROW_BITS'(1);
		ctrl_cur.centre_col = COL_OUT_BITS'(col_m1);
		ctrl_cur.frame_done = (row_inc == h_eff) && (col_inc == w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				if (wrap_col) begin
					col_q <= '0;
					row_q <= wrap_row ? '0 : row_inc[ROW_BITS-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
					row_q <= row_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctrl_s1           <= ctrl_cur;
			col_s1            <= col_cur;
			pix_s1[SCALE_LOW]  <= pix_in.pix_low;
			pix_s1[SCALE_MID]  <= pix_in.pix_mid;
			pix_s1[SCALE_HIGH] <= pix_in.pix_high;
		end
	end

	// Per scale word: upper half is the older line, lower half the newer one
	always_comb begin
		for (int s = 0; s < SCALES; s++) begin
			top_s1[s] = rd_data[s*2*PIXEL_BITS + PIXEL_BITS +: PIXEL_BITS];
			mid_s1[s] = rd_data[s*2*PIXEL_BITS +: PIXEL_BITS];
			wr_data[s*2*PIXEL_BITS + PIXEL_BITS +: PIXEL_BITS] = mid_s1[s];
			wr_data[s*2*PIXEL_BITS +: PIXEL_BITS]              = pix_s1[s];
		end
	end

	ssed_line_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (col_cur),
		.rd_data (rd_data),
		.wr_en   (v_s1),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	ssed_window #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (v_s1),
		.ctrl_in  (ctrl_s1),
		.col_top  (top_s1),
		.col_mid  (mid_s1),
		.col_new  (pix_s1),
		.s2_valid (v_s2),
		.res_push (res_push),
		.res_data (res_data)
	);

	ssed_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.level     (level),
		.res_out   (res_out)
	);

	// Reserve a queue slot for every item still in the pipeline
	assign inflight     = level + (OUT_PTR_BITS+1)'(v_s1) + (OUT_PTR_BITS+1)'(v_s2);
	assign pix_in.ready = (inflight < (OUT_PTR_BITS+1)'(OUT_DEPTH));

`ifndef ASSERT_OFF
	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted pixel did not reach stage 1");

	a_emit_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ctrl_s1.emit) |=> res_push)
		else $error("interior centre did not produce a result");

	a_queue_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		inflight <= (OUT_PTR_BITS+1)'(OUT_DEPTH))
		else $error("output queue overcommitted");
`endif

endmodule

FILE: design/ssed_line_store.sv
module ssed_line_store import ssed_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
	output logic [SCALES*2*PIXEL_BITS-1:0]        rd_data,
	input  logic                                  wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]          wr_addr,
	input  logic [SCALES*2*PIXEL_BITS-1:0]        wr_data
);

	localparam int DW = SCALES * 2 * PIXEL_BITS;

	// One word per column: both stored lines of all three scales
	logic [DW-1:0] mem [MAX_WIDTH];
	logic [DW-1:0] mem_rd_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// Same column read while its write lands: take the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

FILE: design/ssed_window.sv
module ssed_window import ssed_pkg::*; #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift,
	input  ctrl_t                        ctrl_in,
	input  logic signed [PIXEL_BITS-1:0] col_top [SCALES],
	input  logic signed [PIXEL_BITS-1:0] col_mid [SCALES],
	input  logic signed [PIXEL_BITS-1:0] col_new [SCALES],
	output logic                         s2_valid,
	output logic                         res_push,
	output res_t                         res_data
);

	logic signed [PIXEL_BITS-1:0] win_q [WIN_SIZE];
	ctrl_t                        ctrl_s2;
	logic                         v_s2;
	logic [COUNT_BITS-1:0]        total_q;
	logic [COUNT_BITS-1:0]        base;
	logic [COUNT_BITS-1:0]        total_next;
	logic                         gt;
	logic                         lt;
	logic                         ext;
	logic                         bump;

	// Per scale: taps r*3+c, column 2 is the newest
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int s = 0; s < SCALES; s++) begin
				for (int r = 0; r < ROW_TAPS; r++) begin
					win_q[s*SCALE_TAPS + r*ROW_TAPS]     <= win_q[s*SCALE_TAPS + r*ROW_TAPS + 1];
					win_q[s*SCALE_TAPS + r*ROW_TAPS + 1] <= win_q[s*SCALE_TAPS + r*ROW_TAPS + 2];
				end
				win_q[s*SCALE_TAPS + 2] <= col_top[s];
				win_q[s*SCALE_TAPS + 5] <= col_mid[s];
				win_q[s*SCALE_TAPS + 8] <= col_new[s];
			end
			ctrl_s2 <= ctrl_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			total_q <= '0;
		end else begin
			v_s2 <= shift;
			if (v_s2) begin
				total_q <= total_next;
			end
		end
	end

	always_comb begin
		gt = 1'b1;
		lt = 1'b1;
		for (int k = 0; k < WIN_SIZE; k++) begin
			if (k != WIN_CENTRE) begin
				if (!(win_q[WIN_CENTRE] > win_q[k])) gt = 1'b0;
				if (!(win_q[WIN_CENTRE] < win_q[k])) lt = 1'b0;
			end
		end
	end

	assign ext        = gt || lt;
	assign base       = ctrl_s2.clr ? '0 : total_q;
	assign bump       = ctrl_s2.emit && ext && (base != COUNT_MAX);
	assign total_next = base + COUNT_BITS'(bump);

	assign s2_valid = v_s2;
	assign res_push = v_s2 && ctrl_s2.emit;

	always_comb begin
		res_data.centre_row    = ctrl_s2.centre_row;
		res_data.centre_col    = ctrl_s2.centre_col;
		res_data.is_extremum   = ext;
		res_data.extrema_count = total_next;
		res_data.frame_done    = ctrl_s2.frame_done;
	end

endmodule

FILE: design/ssed_out_fifo.sv
module ssed_out_fifo import ssed_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  res_t                  push_data,
	output logic [OUT_PTR_BITS:0] level,
	ssed_res_if.source            res_out
);

	res_t                    mem_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0] wr_ptr_q;
	logic [OUT_PTR_BITS-1:0] rd_ptr_q;
	logic [OUT_PTR_BITS:0]   cnt_q;
	logic                    pop;
	res_t                    head;

	assign pop = res_out.valid && res_out.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (OUT_PTR_BITS+1)'(push) - (OUT_PTR_BITS+1)'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign level = cnt_q;

	assign res_out.valid         = (cnt_q != '0);
	assign res_out.centre_row    = head.centre_row;
	assign res_out.centre_col    = head.centre_col;
	assign res_out.is_extremum   = head.is_extremum;
	assign res_out.extrema_count = head.extrema_count;
	assign res_out.frame_done    = head.frame_done;

endmodule

FILE: test/tb_scale_space_extrema_detector_unit.sv
`timescale 1ns / 100ps

module tb_scale_space_extrema_detector_unit;
	import ssed_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int PIX_BITS       = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 350;
	localparam int WIDE_EXTRA     = 16;
	localparam int TALL_ROWS      = 100;

	typedef logic signed [PIX_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t mid;
		sample_t low;
		sample_t high;
		logic    sof;
	} pix_item_t;

	typedef struct {
		bit   pinned;
		res_t want;
	} pin_t;

	typedef struct {
		pix_item_t item;
		bit        pinned;
		res_t      want;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	ssed_pix_if #(.PIXEL_BITS(PIX_BITS)) pix_if ();
	ssed_res_if res_if ();

	scale_space_extrema_detector_unit #(
		.MAX_WIDTH (MAX_W),
		.PIXEL_BITS(PIX_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (pix_if),
		.res_out  (res_if)
	);

	// Detector model state
	logic [CFG_BITS-1:0]   width_reg = WIDTH_RESET;
	logic [CFG_BITS-1:0]   height_reg = HEIGHT_RESET;
	int                    pos_row = 0;
	int                    pos_col = 0;
	logic [COUNT_BITS-1:0] extrema_seen = '0;
	sample_t               line_mem [SCALES][2*MAX_W] = '{default: '0};
	sample_t               window [WIN_SIZE] = '{default: '0};

	res_t      expected_results [$];
	pin_t      pinned_q [$];
	stim_row_t directed_rows [$];

	int errors = 0;
	int idle_cycles = 0;
	int ready_idle;
	bit hold_req;
	bit hold_seen;
	bit tx_calm;
	bit rx_calm;

	function automatic int size_eff(input logic [CFG_BITS-1:0] v, input int maxv);
		int x;
		x = int'(v);
		if (x < int'(MIN_SIZE))
			x = int'(MIN_SIZE);
		if (x > maxv)
			x = maxv;
		return x;
	endfunction

	function automatic int pick_gap(input bit calm);
		int n;
		if (calm)
			return 0;
		n = $urandom_range(0, 99);
		if (n < 65)
			return 0;
		else if (n < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t pick_sample(input int mode);
		int n;
		case (mode)
			1: return sample_t'(int'($urandom_range(0, 4)) - 2);
			2: begin
				n = $urandom_range(0, 3);
				case (n)
					0: return sample_t'(-32768);
					1: return sample_t'(32767);
					2: return sample_t'(0);
					default: return sample_t'(-1);
				endcase
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic pix_item_t random_item(input int mode, input bit sof);
		pix_item_t it;
		it.mid  = pick_sample(mode);
		it.low  = pick_sample(mode);
		it.high = pick_sample(mode);
		it.sof  = sof;
		return it;
	endfunction

	// Window shift, line store update, 26-neighbour test and raster advance
	function automatic void predict_pixel(input pix_item_t it, output bit emits, output res_t r);
		int      w;
		int      h;
		int      row;
		int      col;
		int      base;
		sample_t v [SCALES];
		sample_t top;
		sample_t midl;
		sample_t m;
		bit      gt;
		bit      lt;
		bit      ext;
		w = size_eff(width_reg, MAX_W);
		h = size_eff(height_reg, int'(MAX_HEIGHT));
		v[SCALE_LOW]  = it.low;
		v[SCALE_MID]  = it.mid;
		v[SCALE_HIGH] = it.high;
		if (it.sof) begin
			pos_row = 0;
			pos_col = 0;
		end
		row = pos_row;
		col = (pos_col >= MAX_W) ? MAX_W - 1 : pos_col;
		if (row == 0 && col == 0)
			extrema_seen = '0;
		for (int s = 0; s < SCALES; s++) begin
			base = s * SCALE_TAPS;
			top  = line_mem[s][col];
			midl = line_mem[s][MAX_W + col];
			for (int k = 0; k < ROW_TAPS; k++) begin
				window[base + k*ROW_TAPS]     = window[base + k*ROW_TAPS + 1];
				window[base + k*ROW_TAPS + 1] = window[base + k*ROW_TAPS + 2];
			end
			window[base + ROW_TAPS - 1]   = top;
			window[base + 2*ROW_TAPS - 1] = midl;
			window[base + 3*ROW_TAPS - 1] = v[s];
			line_mem[s][col]         = midl;
			line_mem[s][MAX_W + col] = v[s];
		end
		emits = 1'b0;
		r     = '0;
		if (row >= 2 && col >= 2) begin
			m  = window[WIN_CENTRE];
			gt = 1'b1;
			lt = 1'b1;
			for (int k = 0; k < WIN_SIZE; k++) begin
				if (k != WIN_CENTRE) begin
					if (!(m > window[k]))
						gt = 1'b0;
					if (!(m < window[k]))
						lt = 1'b0;
				end
			end
			ext = gt || lt;
			if (ext && extrema_seen != COUNT_MAX)
				extrema_seen++;
			r.centre_row    = ROW_BITS'(row - 1);
			r.centre_col    = COL_OUT_BITS'(col - 1);
			r.is_extremum   = ext;
			r.extrema_count = extrema_seen;
			r.frame_done    = (row == h - 1 && col == w - 1);
			emits = 1'b1;
		end
		if (col + 1 >= w) begin
			pos_col = 0;
			pos_row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			pos_col = col + 1;
			pos_row = row;
		end
	endfunction

	task automatic send_pixel(input pix_item_t it, input bit pinned, input res_t want);
		int   gap;
		pin_t pin;
		gap = pick_gap(tx_calm);
		pin.pinned = pinned;
		pin.want   = want;
		pinned_q.push_back(pin);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid          <= 1'b1;
		pix_if.pix_mid        <= it.mid;
		pix_if.pix_low        <= it.low;
		pix_if.pix_high       <= it.high;
		pix_if.start_of_frame <= it.sof;
		do @(posedge clk); while (!pix_if.ready);
	endtask

	task automatic write_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Border pixels give no result, so the bench waits on after the expected results drain to let the pipe empty.
	task automatic settle();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// 3x3 frame, centre in the middle scale; tie puts the centre value into one
	// lower-scale neighbour. Only the last pixel carries a result.
	task automatic add_frame(input sample_t centre, input sample_t other, input bit sof,
		input bit tie, input res_t want);
		stim_row_t row;
		for (int p = 0; p < SCALE_TAPS; p++) begin
			row.item.mid  = (p == SCALE_TAPS / 2) ? centre : other;
			row.item.low  = (tie && p == 0) ? centre : other;
			row.item.high = other;
			row.item.sof  = sof && p == 0;
			row.pinned    = (p == SCALE_TAPS - 1);
			row.want      = want;
			directed_rows.push_back(row);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin : observe
		pix_item_t seen;
		res_t      exp_r;
		res_t      pred_r;
		pin_t      pin;
		bit        emits;
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_IMAGE_HEIGHT)
					height_reg = cfg_data;
			end
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: centre_row %0d centre_col %0d",
						res_if.centre_row, res_if.centre_col);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (res_if.centre_row !== exp_r.centre_row) begin
						$error("centre_row: expected %0d, got %0d",
							exp_r.centre_row, res_if.centre_row);
						errors++;
					end
					if (res_if.centre_col !== exp_r.centre_col) begin
						$error("centre_col: expected %0d, got %0d",
							exp_r.centre_col, res_if.centre_col);
						errors++;
					end
					if (res_if.is_extremum !== exp_r.is_extremum) begin
						$error("is_extremum: expected %0d, got %0d",
							exp_r.is_extremum, res_if.is_extremum);
						errors++;
					end
					if (res_if.extrema_count !== exp_r.extrema_count) begin
						$error("extrema_count: expected %0d, got %0d",
							exp_r.extrema_count, res_if.extrema_count);
						errors++;
					end
					if (res_if.frame_done !== exp_r.frame_done) begin
						$error("frame_done: expected %0d, got %0d",
							exp_r.frame_done, res_if.frame_done);
						errors++;
					end
				end
			end
			if (pix_if.valid && pix_if.ready) begin
				seen.mid  = pix_if.pix_mid;
				seen.low  = pix_if.pix_low;
				seen.high = pix_if.pix_high;
				seen.sof  = pix_if.start_of_frame;
				predict_pixel(seen, emits, pred_r);
				pin = pinned_q.pop_front();
				if (pin.pinned)
					expected_results.push_back(pin.want);
				else if (emits)
					expected_results.push_back(pred_r);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off when requested
	initial begin
		res_if.ready = 1'b0;
		ready_idle   = 0;
		hold_seen    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen)
				ready_idle = HOLD_CYCLES;
			hold_seen = hold_req;
			if (ready_idle > 0) begin
				res_if.ready <= 1'b0;
				ready_idle--;
			end else begin
				res_if.ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					ready_idle = pick_gap(1'b0);
			end
		end
	end

	initial begin
		@(posedge clk);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int        w_val;
		int        h_val;
		int        wf;
		int        hf;
		int        count;
		int        mode;
		int        sent;
		int        n;
		bit        restart;
		bit        sof;
		bit        calm;
		stim_row_t noise;

		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		pix_if.valid          = 1'b0;
		pix_if.pix_mid        = '0;
		pix_if.pix_low        = '0;
		pix_if.pix_high       = '0;
		pix_if.start_of_frame = 1'b0;

		hold_req    = 1'b0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;

		// strict maximum at full scale, then strict minimum after the wrap
		add_frame(sample_t'(32767), sample_t'(-32768), 1'b1, 1'b0,
			res_t'{centre_row: 10'd1, centre_col: 10'd1, is_extremum: 1'b1,
			extrema_count: 20'd1, frame_done: 1'b1});
		add_frame(sample_t'(-32768), sample_t'(32767), 1'b0, 1'b0,
			res_t'{centre_row: 10'd1, centre_col: 10'd1, is_extremum: 1'b1,
			extrema_count: 20'd1, frame_done: 1'b1});
		for (int i = 0; i < 2; i++) begin
			noise.item   = random_item(1, 1'b0);
			noise.pinned = 1'b0;
			noise.want   = '0;
			directed_rows.push_back(noise);
		end
		// frame restart mid-stream; an equal neighbour defeats the extremum
		add_frame(sample_t'(5), sample_t'(-1), 1'b1, 1'b1,
			res_t'{centre_row: 10'd1, centre_col: 10'd1, is_extremum: 1'b0,
			extrema_count: 20'd0, frame_done: 1'b1});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// below-minimum sizes clamp to 3x3
		write_size(11'd0, 11'd2);
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);
		pix_if.valid <= 1'b0;
		settle();

		// widest row, clamped from the top register value; the row count seen
		// in the next phase shows where the row wrapped
		write_size(11'd2047, 11'd3);
		for (int i = 0; i < MAX_W + WIDE_EXTRA; i++)
			send_pixel(random_item(0, i == 0), 1'b0, '0);
		pix_if.valid <= 1'b0;
		settle();

		// tall frame continued from there; output held off so the block backs up
		write_size(11'd1, MAX_HEIGHT);
		tx_calm  = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < TALL_ROWS * 3; i++)
			send_pixel(random_item(i % 3, 1'b0), 1'b0, '0);
		tx_calm  = 1'b0;
		hold_req = 1'b0;
		pix_if.valid <= 1'b0;
		settle();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			n = $urandom_range(0, 19);
			if (n < 2)
				w_val = $urandom_range(0, 2);
			else if (n < 4)
				w_val = $urandom_range(13, 40);
			else
				w_val = $urandom_range(3, 12);
			n = $urandom_range(0, 19);
			if (n < 2)
				h_val = $urandom_range(0, 2);
			else if (n == 2)
				h_val = $urandom_range(1025, 2047);
			else
				h_val = $urandom_range(3, 8);
			wf = size_eff(CFG_BITS'(w_val), MAX_W);
			hf = size_eff(CFG_BITS'(h_val), int'(MAX_HEIGHT));
			// a wider row would read line store columns never filled: restart
			restart = (wf > size_eff(width_reg, MAX_W)) || ($urandom_range(0, 1) == 1);
			write_size(CFG_BITS'(w_val), CFG_BITS'(h_val));
			count = $urandom_range(1, 2) * wf * hf + $urandom_range(0, 2 * wf);
			if (count > 120)
				count = $urandom_range(40, 120);
			if (count > RANDOM_ITEMS - sent)
				count = RANDOM_ITEMS - sent;
			mode = $urandom_range(0, 2);
			calm = ($urandom_range(0, 4) == 0);
			tx_calm = calm;
			rx_calm = calm;
			for (int i = 0; i < count; i++) begin
				sof = (i == 0) ? restart : ($urandom_range(0, 49) == 0);
				send_pixel(random_item(mode, sof), 1'b0, '0);
			end
			sent += count;
			pix_if.valid <= 1'b0;
			settle();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
